@@ src/slcd_pkg.sv @@
// Shared types and constants for the serial line command decoder.
`timescale 1ns / 1ps

package slcd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_B     = 8'd66;
    localparam logic [7:0] CH_E     = 8'd69;
    localparam logic [7:0] CH_L     = 8'd76;
    localparam logic [7:0] CH_N     = 8'd78;
    localparam logic [7:0] CH_O     = 8'd79;
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_T     = 8'd84;
    localparam logic [7:0] CH_V     = 8'd86;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_Y     = 8'd89;
    localparam logic [7:0] CH_UNDER = 8'd95;

    typedef enum logic [1:0] {
        KIND_PLAY   = 2'd0,
        KIND_NEXT   = 2'd1,
        KIND_VOLUME = 2'd2
    } kind_t;

    // Classified byte handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic       term;
        logic       blank;
        logic       space;
        logic       digit;
        logic [3:0] dval;
    } token_t;

endpackage

@@ src/slcd_front.sv @@
// Front end: accepts received bytes and classifies them into tokens.
`timescale 1ns / 1ps

module slcd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          rx_byte,
    output logic                tok_valid,
    input  logic                tok_ready,
    output slcd_pkg::token_t    tok
);

    logic             valid_reg;
    logic             valid_next;
    slcd_pkg::token_t tok_reg;
    slcd_pkg::token_t tok_class;
    logic             accept;

    always_comb
    begin
        tok_class.data  = rx_byte;
        tok_class.term  = (rx_byte == slcd_pkg::CH_LF) || (rx_byte == slcd_pkg::CH_CR);
        tok_class.blank = (rx_byte == slcd_pkg::CH_SPACE) || (rx_byte == slcd_pkg::CH_TAB);
        tok_class.space = (rx_byte == slcd_pkg::CH_SPACE)
                        || ((rx_byte >= slcd_pkg::CH_TAB) && (rx_byte <= slcd_pkg::CH_CR));
        tok_class.digit = (rx_byte >= slcd_pkg::CH_ZERO) && (rx_byte <= slcd_pkg::CH_NINE);
        tok_class.dval  = rx_byte[3:0];
    end

    assign full       = valid_reg && !tok_ready;
    assign accept     = push && !full;
    assign valid_next = accept || (valid_reg && !tok_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= tok_class;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

@@ src/slcd_queue.sv @@
// Short token queue between the front end and the back end.
`timescale 1ns / 1ps

module slcd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  slcd_pkg::token_t    in_tok,
    output logic                out_valid,
    input  logic                out_ready,
    output slcd_pkg::token_t    out_tok
);

    slcd_pkg::token_t                   mem_reg [slcd_pkg::QUEUE_DEPTH];
    logic [slcd_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [slcd_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [slcd_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [slcd_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [slcd_pkg::QCNT_W-1:0]        count_reg;
    logic [slcd_pkg::QCNT_W-1:0]        count_next;
    logic                               wr_en;
    logic                               rd_en;

    assign in_ready  = (count_reg != slcd_pkg::QCNT_W'(slcd_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;
    assign out_tok   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

@@ src/slcd_back.sv @@
// Back end: line matcher, volume number accumulator and result queue.
`timescale 1ns / 1ps

module slcd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    output logic                tok_ready,
    input  slcd_pkg::token_t    tok,
    input  logic                events_enabled,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          event_kind,
    output logic signed [31:0]  volume_value
);

    typedef enum logic [19:0] {
        PH_START    = 20'h00001,
        PH_B_T      = 20'h00002,
        PH_B_N      = 20'h00004,
        PH_B_UNDER  = 20'h00008,
        PH_B_PN     = 20'h00010,
        PH_P_L      = 20'h00020,
        PH_P_A      = 20'h00040,
        PH_P_Y      = 20'h00080,
        PH_PLAY     = 20'h00100,
        PH_N_E      = 20'h00200,
        PH_N_X      = 20'h00400,
        PH_N_T      = 20'h00800,
        PH_NEXT     = 20'h01000,
        PH_JUNK     = 20'h02000,
        PH_V_O      = 20'h04000,
        PH_V_L      = 20'h08000,
        PH_V_COLON  = 20'h10000,
        PH_VOL_LEAD = 20'h20000,
        PH_VOL_NUM  = 20'h40000,
        PH_VOL_DONE = 20'h80000
    } phase_t;

    phase_t         phase_reg;
    phase_t         phase_next;
    logic [31:0]    mag_reg;
    logic [31:0]    mag_next;
    logic           neg_reg;
    logic           neg_next;
    logic           ovf_reg;
    logic           ovf_next;
    logic           seen_reg;
    logic           seen_next;

    logic [35:0]    acc;
    logic           take;
    logic           line_hit;
    slcd_pkg::kind_t line_kind;
    logic [31:0]    line_vol;
    logic           res_push;

    slcd_pkg::kind_t             res_kind_reg [slcd_pkg::QUEUE_DEPTH];
    logic [31:0]                 res_vol_reg  [slcd_pkg::QUEUE_DEPTH];
    logic [slcd_pkg::QPTR_W-1:0] res_wr_reg;
    logic [slcd_pkg::QPTR_W-1:0] res_wr_next;
    logic [slcd_pkg::QPTR_W-1:0] res_rd_reg;
    logic [slcd_pkg::QPTR_W-1:0] res_rd_next;
    logic [slcd_pkg::QCNT_W-1:0] res_cnt_reg;
    logic [slcd_pkg::QCNT_W-1:0] res_cnt_next;
    logic                        res_pop;

    assign tok_ready = (res_cnt_reg != slcd_pkg::QCNT_W'(slcd_pkg::QUEUE_DEPTH));
    assign take      = tok_valid && tok_ready;

    // mag * 10 + digit
    assign acc = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {32'b0, tok.dval};

    always_comb
    begin
        line_hit  = 1'b0;
        line_kind = slcd_pkg::KIND_PLAY;
        line_vol  = '0;
        unique case (phase_reg)
            PH_PLAY:
            begin
                line_hit  = 1'b1;
                line_kind = slcd_pkg::KIND_PLAY;
            end
            PH_NEXT:
            begin
                line_hit  = 1'b1;
                line_kind = slcd_pkg::KIND_NEXT;
            end
            PH_VOL_LEAD, PH_VOL_NUM, PH_VOL_DONE:
            begin
                line_hit  = 1'b1;
                line_kind = slcd_pkg::KIND_VOLUME;
                if (!seen_reg || ovf_reg)
                begin
                    line_vol = '0;
                end
                else if (neg_reg)
                begin
                    line_vol = 32'd0 - mag_reg;
                end
                else if (mag_reg > (slcd_pkg::MAG_LIMIT - 32'd1))
                begin
                    line_vol = '0;
                end
                else
                begin
                    line_vol = mag_reg;
                end
            end
            default:
            begin
                line_hit = 1'b0;
            end
        endcase
    end

    assign res_push = take && tok.term && line_hit && events_enabled;

    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        seen_next  = seen_reg;
        if (take)
        begin
            if (tok.term)
            begin
                phase_next = PH_START;
                mag_next   = '0;
                neg_next   = 1'b0;
                ovf_next   = 1'b0;
                seen_next  = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (tok.data == slcd_pkg::CH_B)
                        begin
                            phase_next = PH_B_T;
                        end
                        else if (tok.data == slcd_pkg::CH_V)
                        begin
                            phase_next = PH_V_O;
                        end
                        else
                        begin
                            phase_next = PH_JUNK;
                        end
                    end
                    PH_B_T:     phase_next = (tok.data == slcd_pkg::CH_T) ? PH_B_N : PH_JUNK;
                    PH_B_N:     phase_next = (tok.data == slcd_pkg::CH_N) ? PH_B_UNDER : PH_JUNK;
                    PH_B_UNDER: phase_next = (tok.data == slcd_pkg::CH_UNDER) ? PH_B_PN : PH_JUNK;
                    PH_B_PN:
                    begin
                        if (tok.data == slcd_pkg::CH_P)
                        begin
                            phase_next = PH_P_L;
                        end
                        else if (tok.data == slcd_pkg::CH_N)
                        begin
                            phase_next = PH_N_E;
                        end
                        else
                        begin
                            phase_next = PH_JUNK;
                        end
                    end
                    PH_P_L:     phase_next = (tok.data == slcd_pkg::CH_L) ? PH_P_A : PH_JUNK;
                    PH_P_A:     phase_next = (tok.data == slcd_pkg::CH_A) ? PH_P_Y : PH_JUNK;
                    PH_P_Y:     phase_next = (tok.data == slcd_pkg::CH_Y) ? PH_PLAY : PH_JUNK;
                    PH_PLAY:    phase_next = tok.blank ? PH_PLAY : PH_JUNK;
                    PH_N_E:     phase_next = (tok.data == slcd_pkg::CH_E) ? PH_N_X : PH_JUNK;
                    PH_N_X:     phase_next = (tok.data == slcd_pkg::CH_X) ? PH_N_T : PH_JUNK;
                    PH_N_T:     phase_next = (tok.data == slcd_pkg::CH_T) ? PH_NEXT : PH_JUNK;
                    PH_NEXT:    phase_next = tok.blank ? PH_NEXT : PH_JUNK;
                    PH_V_O:     phase_next = (tok.data == slcd_pkg::CH_O) ? PH_V_L : PH_JUNK;
                    PH_V_L:     phase_next = (tok.data == slcd_pkg::CH_L) ? PH_V_COLON : PH_JUNK;
                    PH_V_COLON:
                    begin
                        phase_next = (tok.data == slcd_pkg::CH_COLON) ? PH_VOL_LEAD : PH_JUNK;
                    end
                    PH_VOL_LEAD, PH_VOL_NUM:
                    begin
                        if (tok.digit)
                        begin
                            seen_next  = 1'b1;
                            phase_next = PH_VOL_NUM;
                            if (!ovf_reg)
                            begin
                                if (acc > {4'b0, slcd_pkg::MAG_LIMIT})
                                begin
                                    ovf_next = 1'b1;
                                    mag_next = slcd_pkg::MAG_LIMIT;
                                end
                                else
                                begin
                                    mag_next = acc[31:0];
                                end
                            end
                        end
                        else if ((phase_reg == PH_VOL_LEAD) && tok.space)
                        begin
                            phase_next = PH_VOL_LEAD;
                        end
                        else if ((phase_reg == PH_VOL_LEAD)
                                 && ((tok.data == slcd_pkg::CH_PLUS)
                                     || (tok.data == slcd_pkg::CH_MINUS)))
                        begin
                            neg_next   = (tok.data == slcd_pkg::CH_MINUS);
                            phase_next = PH_VOL_NUM;
                        end
                        else
                        begin
                            phase_next = PH_VOL_DONE;
                        end
                    end
                    PH_VOL_DONE: phase_next = PH_VOL_DONE;
                    default:     phase_next = PH_JUNK;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
        end
    end

    // result queue
    assign empty        = (res_cnt_reg == '0);
    assign res_pop      = pop && !empty;
    assign event_kind   = res_kind_reg[res_rd_reg];
    assign volume_value = res_vol_reg[res_rd_reg];

    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (res_push)
        begin
            res_wr_next = (res_wr_reg == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : res_wr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rd_next = (res_rd_reg == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : res_rd_reg + 1'b1;
        end
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_wr_reg  <= res_wr_next;
            res_rd_reg  <= res_rd_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_kind_reg[res_wr_reg] <= line_kind;
            res_vol_reg[res_wr_reg]  <= line_vol;
        end
    end

endmodule

@@ src/serial_line_command_decoder_unit.sv @@
// Top level of the serial line command decoder.
`timescale 1ns / 1ps

// Decodes a stream of received bytes into button and volume events. One byte
// is taken per clock while full is low; the front end registers and classifies
// it, a two-entry queue decouples it from the back end, which advances the
// line matcher and the decimal accumulator (one multiply-by-ten and add) per
// token. A line terminator that completes a command passes the front-end
// register, the token queue and the result queue before its event shows on
// the result ports. The two-entry result queue sets the stall point: when it
// is full, bytes back up into the token queue and then full rises. Nothing is
// delivered while events_enabled is low; set it while the block is idle.
module serial_line_command_decoder_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          rx_byte,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          event_kind,
    output logic signed [31:0]  volume_value,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    logic             fe_valid;
    logic             fe_ready;
    slcd_pkg::token_t fe_tok;
    logic             be_valid;
    logic             be_ready;
    slcd_pkg::token_t be_tok;
    logic             events_enabled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            events_enabled_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            events_enabled_reg <= cfg_wdata;
        end
    end

    slcd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .tok_valid (fe_valid),
        .tok_ready (fe_ready),
        .tok       (fe_tok)
    );

    slcd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_tok    (fe_tok),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_tok   (be_tok)
    );

    slcd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok_valid      (be_valid),
        .tok_ready      (be_ready),
        .tok            (be_tok),
        .events_enabled (events_enabled_reg),
        .empty          (empty),
        .pop            (pop),
        .event_kind     (event_kind),
        .volume_value   (volume_value)
    );

`ifndef SYNTHESIS
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_kind == slcd_pkg::KIND_PLAY || event_kind == slcd_pkg::KIND_NEXT
                    || event_kind == slcd_pkg::KIND_VOLUME))
        else $error("result transaction carries an undefined event kind");

    a_button_no_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind != slcd_pkg::KIND_VOLUME) |-> volume_value == 32'sd0)
        else $error("button event carries a nonzero volume");

    a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!events_enabled_reg && empty) |=> empty)
        else $error("result produced while events are disabled");

    a_token_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fe_valid && !fe_ready) |=> (fe_valid && $stable(fe_tok)))
        else $error("stalled token changed before the queue took it");
`endif

endmodule

@@ tb/slcd_event_checker.sv @@
// Checker for the serial line command decoder: line predictor, event store and compare.
`timescale 1ns / 1ps

module slcd_event_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         rx_byte,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         event_kind,
    input  logic signed [31:0] volume_value,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output int                 fail_count,
    output int                 owed
);

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [4:0] {
        LN_START, LN_B, LN_BT, LN_BTN, LN_BTN_U,
        LN_P, LN_PL, LN_PLA, LN_PLAY, LN_PLAY_TRAIL,
        LN_N, LN_NE, LN_NEX, LN_NEXT, LN_NEXT_TRAIL,
        LN_V, LN_VO, LN_VOL, LN_LEAD, LN_SIGN, LN_DIGITS, LN_TAIL,
        LN_SKIP
    } line_state_t;

    typedef struct packed {
        slcd_pkg::kind_t    kind;
        logic signed [31:0] level;
    } slcd_event_t;

    line_state_t   line_state;
    logic [31:0]   magnitude;
    logic          negative;
    logic          saturated;
    logic          have_digit;
    logic          enabled;
    slcd_event_t   owed_events[$];

    function automatic line_state_t follow(logic [7:0] b, logic [7:0] want,
                                           line_state_t nxt);
        return (b == want) ? nxt : LN_SKIP;
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b == slcd_pkg::CH_SPACE || (b >= slcd_pkg::CH_TAB && b <= slcd_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= slcd_pkg::CH_ZERO && b <= slcd_pkg::CH_NINE;
    endfunction

    task automatic clear_line();
        line_state = LN_START;
        magnitude  = '0;
        negative   = 1'b0;
        saturated  = 1'b0;
        have_digit = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] b);
        logic [63:0] acc;
        have_digit = 1'b1;
        line_state = LN_DIGITS;
        if (!saturated)
        begin
            acc = {32'd0, magnitude} * 64'd10 + {56'd0, b - slcd_pkg::CH_ZERO};
            if (acc > {32'd0, slcd_pkg::MAG_LIMIT})
            begin
                saturated = 1'b1;
                magnitude = slcd_pkg::MAG_LIMIT;
            end
            else
                magnitude = acc[31:0];
        end
    endtask

    task automatic step_line(input logic [7:0] b);
        case (line_state)
            LN_START:
                if (b == slcd_pkg::CH_B)
                    line_state = LN_B;
                else if (b == slcd_pkg::CH_V)
                    line_state = LN_V;
                else
                    line_state = LN_SKIP;
            LN_B:     line_state = follow(b, slcd_pkg::CH_T, LN_BT);
            LN_BT:    line_state = follow(b, slcd_pkg::CH_N, LN_BTN);
            LN_BTN:   line_state = follow(b, slcd_pkg::CH_UNDER, LN_BTN_U);
            LN_BTN_U:
                if (b == slcd_pkg::CH_P)
                    line_state = LN_P;
                else if (b == slcd_pkg::CH_N)
                    line_state = LN_N;
                else
                    line_state = LN_SKIP;
            LN_P:     line_state = follow(b, slcd_pkg::CH_L, LN_PL);
            LN_PL:    line_state = follow(b, slcd_pkg::CH_A, LN_PLA);
            LN_PLA:   line_state = follow(b, slcd_pkg::CH_Y, LN_PLAY);
            LN_N:     line_state = follow(b, slcd_pkg::CH_E, LN_NE);
            LN_NE:    line_state = follow(b, slcd_pkg::CH_X, LN_NEX);
            LN_NEX:   line_state = follow(b, slcd_pkg::CH_T, LN_NEXT);
            LN_PLAY, LN_PLAY_TRAIL:
                line_state = (b == slcd_pkg::CH_SPACE || b == slcd_pkg::CH_TAB)
                           ? LN_PLAY_TRAIL : LN_SKIP;
            LN_NEXT, LN_NEXT_TRAIL:
                line_state = (b == slcd_pkg::CH_SPACE || b == slcd_pkg::CH_TAB)
                           ? LN_NEXT_TRAIL : LN_SKIP;
            LN_V:     line_state = follow(b, slcd_pkg::CH_O, LN_VO);
            LN_VO:    line_state = follow(b, slcd_pkg::CH_L, LN_VOL);
            LN_VOL:   line_state = follow(b, slcd_pkg::CH_COLON, LN_LEAD);
            LN_LEAD:
                if (is_blank(b))
                    line_state = LN_LEAD;
                else if (b == slcd_pkg::CH_PLUS || b == slcd_pkg::CH_MINUS)
                begin
                    negative   = (b == slcd_pkg::CH_MINUS);
                    line_state = LN_SIGN;
                end
                else if (is_digit(b))
                    take_digit(b);
                else
                    line_state = LN_TAIL;
            LN_SIGN, LN_DIGITS:
                if (is_digit(b))
                    take_digit(b);
                else
                    line_state = LN_TAIL;
            LN_TAIL:  line_state = LN_TAIL;
            default:  line_state = LN_SKIP;
        endcase
    endtask

    function automatic logic signed [31:0] volume_of();
        if (!have_digit || saturated)
            return '0;
        if (negative)
            return $signed(32'd0 - magnitude);
        if (magnitude > slcd_pkg::MAG_LIMIT - 32'd1)
            return '0;
        return $signed(magnitude);
    endfunction

    // Terminators close the line; everything else advances the matcher.
    task automatic absorb_byte(input logic [7:0] b);
        slcd_event_t ev;
        logic        found;
        if (b != slcd_pkg::CH_LF && b != slcd_pkg::CH_CR)
            step_line(b);
        else
        begin
            found    = 1'b1;
            ev.level = '0;
            case (line_state)
                LN_PLAY, LN_PLAY_TRAIL: ev.kind = slcd_pkg::KIND_PLAY;
                LN_NEXT, LN_NEXT_TRAIL: ev.kind = slcd_pkg::KIND_NEXT;
                LN_LEAD, LN_SIGN, LN_DIGITS, LN_TAIL:
                begin
                    ev.kind  = slcd_pkg::KIND_VOLUME;
                    ev.level = volume_of();
                end
                default:
                begin
                    ev.kind = slcd_pkg::KIND_PLAY;
                    found   = 1'b0;
                end
            endcase
            clear_line();
            if (found && enabled)
                owed_events.push_back(ev);
        end
    endtask

    task automatic check_event();
        slcd_event_t ev;
        if (owed_events.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected event: kind %0d volume %0d", event_kind, volume_value);
        end
        else
        begin
            ev = owed_events.pop_front();
            if (event_kind !== ev.kind || volume_value !== ev.level)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("event mismatch: expected kind %0d volume %0d, %s %0d volume %0d",
                             ev.kind, ev.level, "got kind", event_kind, volume_value);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            enabled = 1'b0;
            owed_events.delete();
            owed = 0;
        end
        else
        begin
            if (pop && !empty)
                check_event();
            if (cfg_we)
                enabled = cfg_wdata;
            if (push && !full)
                absorb_byte(rx_byte);
            owed = owed_events.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the serial line command decoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int          CLK_PERIOD    = 20;
    localparam int          RESET_CYCLES  = 5;
    localparam int          SETTLE_CYCLES = 8;
    localparam longint      CYCLE_LIMIT   = 400000;
    localparam logic [7:0]  CH_VT         = 8'd11;
    localparam logic [7:0]  CH_FF         = 8'd12;
    localparam string       PLAY_WORD     = {"BTN_", "PLAY"};
    localparam string       NEXT_WORD     = {"BTN_", "NEXT"};

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         rx_byte;
    logic               empty;
    logic               pop;
    logic [1:0]         event_kind;
    logic signed [31:0] volume_value;
    logic               cfg_we;
    logic               cfg_wdata;

    int                 fail_count;
    int                 owed;
    bit                 calm = 1'b0;
    int                 bytes_sent = 0;
    longint             cycles = 0;
    logic [7:0]         line_buf[$];

    serial_line_command_decoder_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .volume_value (volume_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    slcd_event_checker scoreboard
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .volume_value (volume_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .owed         (owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Result side: random stall before each pop transaction.
    initial
    begin
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic flush_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic add_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            do b = $urandom_range(0, 255);
            while (b == slcd_pkg::CH_CR || b == slcd_pkg::CH_LF);
            line_buf.push_back(b);
        end
    endtask

    task automatic add_terminator();
        case ($urandom_range(0, 5))
            0: line_buf.push_back(slcd_pkg::CH_CR);
            1: line_buf.push_back(slcd_pkg::CH_LF);
            2:
            begin
                line_buf.push_back(slcd_pkg::CH_CR);
                line_buf.push_back(slcd_pkg::CH_LF);
            end
            3:
            begin
                line_buf.push_back(slcd_pkg::CH_LF);
                line_buf.push_back(slcd_pkg::CH_LF);
            end
            4:
            begin
                line_buf.push_back(slcd_pkg::CH_CR);
                line_buf.push_back(slcd_pkg::CH_LF);
                line_buf.push_back(slcd_pkg::CH_CR);
                line_buf.push_back(slcd_pkg::CH_LF);
            end
            default: line_buf.push_back(slcd_pkg::CH_LF);
        endcase
    endtask

    task automatic add_trailing();
        repeat ($urandom_range(0, 3))
            line_buf.push_back($urandom_range(0, 1) ? slcd_pkg::CH_SPACE : slcd_pkg::CH_TAB);
    endtask

    task automatic add_number();
        logic [63:0] v;
        int          mode;
        mode = $urandom_range(0, 5);
        case (mode)
            0: v = $urandom_range(0, 999);
            1: v = $urandom;
            2: v = 64'd2147483640 + $urandom_range(0, 16);
            3: v = {$urandom, $urandom};
            4:
            begin
                repeat ($urandom_range(1, 12)) line_buf.push_back(slcd_pkg::CH_ZERO);
                v = $urandom_range(0, 99);
            end
            default: v = '0;
        endcase
        if (mode != 5)
            add_text($sformatf("%0d", v));
    endtask

    task automatic make_button(input bit nxt);
        add_text(nxt ? NEXT_WORD : PLAY_WORD);
        add_trailing();
        if ($urandom_range(0, 9) == 0)
            add_noise(1);
        add_terminator();
        flush_line();
    endtask

    task automatic make_volume();
        logic [7:0] ws [4];
        ws = '{slcd_pkg::CH_TAB, CH_VT, CH_FF, slcd_pkg::CH_SPACE};
        add_text("VOL:");
        repeat ($urandom_range(0, 2))
            line_buf.push_back(ws[$urandom_range(0, 3)]);
        case ($urandom_range(0, 3))
            0: line_buf.push_back(slcd_pkg::CH_PLUS);
            1: line_buf.push_back(slcd_pkg::CH_MINUS);
            default: ;
        endcase
        add_number();
        if ($urandom_range(0, 3) == 0)
            add_noise($urandom_range(1, 3));
        add_trailing();
        add_terminator();
        flush_line();
    endtask

    task automatic make_broken();
        string word;
        int    cut;
        case ($urandom_range(0, 2))
            0: word = PLAY_WORD;
            1: word = NEXT_WORD;
            default: word = "VOL:";
        endcase
        case ($urandom_range(0, 2))
            0:
            begin
                cut = $urandom_range(0, word.len() - 1);
                if (cut > 0)
                    add_text(word.substr(0, cut - 1));
                add_noise(1);
            end
            1:
            begin
                line_buf.push_back($urandom_range(0, 1) ? slcd_pkg::CH_SPACE : slcd_pkg::CH_TAB);
                add_text(word);
            end
            default:
            begin
                add_text(word);
                add_noise($urandom_range(1, 3));
            end
        endcase
        add_terminator();
        flush_line();
    endtask

    task automatic random_lines(input int count);
        int stop;
        int pick;
        stop = bytes_sent + count;
        while (bytes_sent < stop)
        begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            if ($urandom_range(0, 59) == 0)
                settle();
            pick = $urandom_range(0, 99);
            if (pick < 20)
                make_button(1'b0);
            else if (pick < 40)
                make_button(1'b1);
            else if (pick < 75)
                make_volume();
            else if (pick < 86)
                make_broken();
            else if (pick < 94)
            begin
                add_noise($urandom_range(1, 12));
                add_terminator();
                flush_line();
            end
            else
            begin
                add_terminator();
                flush_line();
            end
        end
    endtask

    // Hold off the sender until every predicted event has been popped.
    task automatic settle();
        push <= 1'b0;
        do @(negedge clk); while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic directed(input string s);
        add_text(s);
        line_buf.push_back(slcd_pkg::CH_LF);
        flush_line();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        rx_byte   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // events are off after reset
        directed(PLAY_WORD);
        directed("VOL:5");
        write_enable(1'b1);

        add_text(PLAY_WORD);
        line_buf.push_back(slcd_pkg::CH_CR);
        flush_line();
        directed({NEXT_WORD, " \t"});
        directed("VOL:42");
        add_text("VOL: -2147483648");
        line_buf.push_back(slcd_pkg::CH_CR);
        line_buf.push_back(slcd_pkg::CH_LF);
        flush_line();
        directed("VOL:2147483647");
        directed("VOL:2147483648");
        directed("VOL:-2147483649");
        directed("VOL:99999999999999999999");
        directed("VOL:");
        directed("VOL:+");
        directed("VOL:-x5");
        directed("VOL:12ab34");
        directed("VOL:-0");
        add_text("VOL:");
        line_buf.push_back(slcd_pkg::CH_TAB);
        line_buf.push_back(CH_VT);
        line_buf.push_back(CH_FF);
        directed("+007");
        directed({" ", PLAY_WORD});
        directed({PLAY_WORD, "X"});
        directed("BTN_NEX");
        directed("vol:3");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        line_buf.push_back(8'h7F);
        line_buf.push_back(slcd_pkg::CH_LF);
        line_buf.push_back(slcd_pkg::CH_CR);
        line_buf.push_back(slcd_pkg::CH_LF);
        flush_line();
        settle();

        random_lines(600);
        write_enable(1'b0);
        random_lines(130);
        write_enable(1'b1);
        calm = 1'b0;
        random_lines(270);
        settle();
        random_lines(500);

        settle();
        if (fail_count == 0 && owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
